// File: rtl/ipv6lpm_pkg.sv
// shared types and constants for the ipv6 longest prefix match block
`default_nettype none
package ipv6lpm_pkg;

  localparam int ADDR_W  = 128;
  localparam int HALF_W  = 64;
  localparam int INDEX_W = 7;
  localparam int LEN_W   = 8;
  localparam int ACT_W   = 8;
  localparam int COUNT_W = 8;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);
  localparam logic [ACT_W-1:0] ACT_NONE = '0;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  // one word as it travels down the rule pipeline
  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [ADDR_W-1:0]  addr;
    logic [INDEX_W-1:0] index;
    logic [LEN_W-1:0]   plen;
    logic [ACT_W-1:0]   act;
    logic [ACT_W-1:0]   best;
    logic [LEN_W-1:0]   best_len;
  } stage_t;

endpackage
`default_nettype wire

// File: rtl/ipv6lpm_in_if.sv
// input channel: rule writes and address lookups
`default_nettype none
interface ipv6lpm_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [6:0]  rule_index;
  logic [7:0]  rule_prefix_len;
  logic [7:0]  rule_action;

  modport source (output valid, kind, addr_high, addr_low, rule_index,
                  rule_prefix_len, rule_action, input ready);
  modport sink   (input valid, kind, addr_high, addr_low, rule_index,
                  rule_prefix_len, rule_action, output ready);
endinterface
`default_nettype wire

// File: rtl/ipv6lpm_out_if.sv
// result channel: action of the best matching rule
`default_nettype none
interface ipv6lpm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] action;

  modport source (output valid, action, input ready);
  modport sink   (input valid, action, output ready);
endinterface
`default_nettype wire

// File: rtl/ipv6_longest_prefix_match.sv
// ipv6 longest prefix match: one pipeline stage per rule slot
`default_nettype none
// Each rule slot owns one pipeline stage with its own rule registers, so one
// word (rule write or lookup) enters every cycle unless a result is held on
// out_ch. A lookup moves through stage registers st_r[0] to st_r[MAX_RULES-1]
// and its result is shown on out_ch from the last of them. Writes travel
// the same pipeline and update their slot when they pass it, so every lookup
// sees exactly the rules written before it. The whole pipeline holds while a
// result waits on out_ch; writes give no result. Rule registers are not reset;
// rule_count resets to 0.
module ipv6_longest_prefix_match #(
  parameter int MAX_RULES = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  ipv6lpm_in_if.sink      in_ch,
  ipv6lpm_out_if.source   out_ch,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);
  import ipv6lpm_pkg::*;

  logic [COUNT_W-1:0] rule_count_r;
  logic [ADDR_W-1:0]  rnet_r [MAX_RULES];
  logic [LEN_W-1:0]   rlen_r [MAX_RULES];
  logic [ACT_W-1:0]   ract_r [MAX_RULES];
  stage_t             st_r   [MAX_RULES];
  stage_t             st_in  [MAX_RULES];
  stage_t             st_nxt [MAX_RULES];
  stage_t             in_word;
  logic               adv;

  // rule count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_count_r <= '0;
    end else if (cfg_we) begin
      rule_count_r <= cfg_wdata;
    end
  end

  // whole pipeline moves unless a result is held
  assign adv = !(st_r[MAX_RULES-1].valid && st_r[MAX_RULES-1].kind == KIND_LOOKUP)
               || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = st_r[MAX_RULES-1].valid && st_r[MAX_RULES-1].kind == KIND_LOOKUP;
  assign out_ch.action = st_r[MAX_RULES-1].best;

  // input word with an empty best match
  always_comb begin
    in_word.valid    = in_ch.valid;
    in_word.kind     = kind_t'(in_ch.kind);
    in_word.addr     = {in_ch.addr_high, in_ch.addr_low};
    in_word.index    = in_ch.rule_index;
    in_word.plen     = in_ch.rule_prefix_len;
    in_word.act      = in_ch.rule_action;
    in_word.best     = ACT_NONE;
    in_word.best_len = '0;
  end

  for (genvar s = 0; s < MAX_RULES; s++) begin : g_stage
    logic [ADDR_W-1:0] mask;
    logic              hit;

    if (s == 0) begin : g_first
      assign st_in[s] = in_word;
    end else begin : g_next
      assign st_in[s] = st_r[s-1];
    end

    // masked compare against this slot and best match update
    always_comb begin
      mask = ~({ADDR_W{1'b1}} >> rlen_r[s]);
      hit  = st_in[s].valid && st_in[s].kind == KIND_LOOKUP
             && (s < int'(rule_count_r)) && (rlen_r[s] <= MAX_LEN)
             && ((st_in[s].addr & mask) == rnet_r[s])
             && (st_in[s].best == ACT_NONE || rlen_r[s] > st_in[s].best_len);
      st_nxt[s] = st_in[s];
      if (hit) begin
        st_nxt[s].best     = ract_r[s];
        st_nxt[s].best_len = rlen_r[s];
      end
    end

    // stage register
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[s].valid <= 1'b0;
      end else if (adv) begin
        st_r[s] <= st_nxt[s];
      end
    end

    // slot update as a write passes
    always_ff @(posedge clk) begin
      if (adv && st_in[s].valid && st_in[s].kind == KIND_WRITE
          && int'(st_in[s].index) == s) begin
        rnet_r[s] <= st_in[s].addr;
        rlen_r[s] <= st_in[s].plen;
        ract_r[s] <= st_in[s].act;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/ipv6lpm_chk.sv
// port checker for the ipv6 longest prefix match block and its bind
`default_nettype none
module ipv6lpm_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_action
);

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action))
    else $error("result changed while stalled");

  // input stalls exactly with a blocked result
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == !(out_valid && !out_ready))
    else $error("input ready does not follow output stall");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind ipv6_longest_prefix_match ipv6lpm_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_action (out_ch.action)
);
`default_nettype wire
